// File: rtl/mexp_pkg.sv
// mexp_pkg: shared constants and types for the modular exponentiation block.
// No dependencies; used by mexp_mulmod and modular_exponentiation.

package mexp_pkg;

    // default operand width and fixed port widths
    localparam int WORD_BITS_DEF = 32;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;

    // register index, taken from paddr[2]
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    // register reset values
    localparam logic [DATA_W-1:0] EXPONENT_RESET = 32'd1;
    localparam logic [DATA_W-1:0] MODULUS_RESET  = 32'd2;

    // status of the shared multiplier-reducer
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

// File: rtl/mexp_mulmod.sv
// mexp_mulmod: iterative modular multiplier, one bit of operand a per cycle
// (interleaved shift-add with reduction). Depends on mexp_pkg.
// Requires b < m; a may be any value.

module mexp_mulmod #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  logic [WORD_BITS-1:0] m,
    output logic [WORD_BITS-1:0] res,
    output mexp_pkg::mm_stat_t   stat
);

    localparam int CNT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [WORD_BITS-1:0] m_reg, m_next;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [WORD_BITS+1:0] sum;
    logic [WORD_BITS+1:0] m1;
    logic [WORD_BITS+1:0] m2;
    logic [WORD_BITS+1:0] red;

    // one step: r = (2r + a_bit*b) mod m, the sum stays below 3m
    always_comb
    begin
        m1  = {2'b00, m_reg};
        m2  = {1'b0, m_reg, 1'b0};
        sum = {1'b0, r_reg, 1'b0}
            + {2'b00, (a_reg[WORD_BITS-1] ? b_reg : '0)};
        if (sum >= m2)
        begin
            red = sum - m2;
        end
        else if (sum >= m1)
        begin
            red = sum - m1;
        end
        else
        begin
            red = sum;
        end
    end

    // sequencing of the bit steps
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            m_next    = m;
            r_next    = '0;
            cnt_next  = CNT_W'(WORD_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = red[WORD_BITS-1:0];
            a_next   = {a_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands and partial result
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign res       = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/modular_exponentiation.sv
// modular_exponentiation: base^exponent mod modulus, right-to-left square and multiply.
// Depends on mexp_pkg and mexp_mulmod.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid/s_axis_tready    s_axis_tdata[31:0] = base
// m_axis    out        m_axis_tvalid/m_axis_tready    m_axis_tdata[31:0] = power_mod
// apb       in         psel/penable/pwrite, pready=1  0x0 exponent, 0x4 modulus
//
// Work: an item takes 1 + WORD_BITS + popcount(exponent) modular products in the shared
// multiplier-reducer: one reduction, one squaring per exponent bit and one multiply per set bit;
// a modulus below 2 skips the products and yields 0.
// One item is in work at a time; s_axis_tready is high only between items.
// A finished result waits in the output register, the next item is taken meanwhile.
// Reset clears control state and sets exponent to 1, modulus to 2.

module modular_exponentiation #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mexp_pkg::ADDR_W-1:0]   paddr,
    input  logic [mexp_pkg::DATA_W-1:0]   pwdata,
    output logic [mexp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mexp_pkg::DATA_W-1:0]   s_axis_tdata,   // [31:0] base
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mexp_pkg::DATA_W-1:0]   m_axis_tdata    // [31:0] power_mod
);

    localparam int IDX_W = $clog2(WORD_BITS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RED_GO = 3'd1;
    localparam logic [2:0] S_RED    = 3'd2;
    localparam logic [2:0] S_BIT    = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_SQR_GO = 3'd5;
    localparam logic [2:0] S_SQR    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [mexp_pkg::DATA_W-1:0] exponent_reg;
    logic [mexp_pkg::DATA_W-1:0] modulus_reg;
    logic                        cfg_wr;

    logic [2:0]                  state_reg, state_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [WORD_BITS-1:0]        acc_reg, acc_next;
    logic [WORD_BITS-1:0]        sq_reg, sq_next;
    logic                        out_valid_reg, out_valid_next;
    logic [mexp_pkg::DATA_W-1:0] out_data_reg, out_data_next;

    logic [WORD_BITS-1:0]        e_w;
    logic [WORD_BITS-1:0]        m_w;
    logic                        m_small;

    logic                        mm_start;
    logic [WORD_BITS-1:0]        mm_a;
    logic [WORD_BITS-1:0]        mm_b;
    logic [WORD_BITS-1:0]        mm_res;
    mexp_pkg::mm_stat_t          mm_stat;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= mexp_pkg::EXPONENT_RESET;
            modulus_reg  <= mexp_pkg::MODULUS_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == mexp_pkg::REG_MODULUS)
            begin
                modulus_reg <= pwdata;
            end
            else
            begin
                exponent_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == mexp_pkg::REG_MODULUS) ? modulus_reg : exponent_reg;

    // operand views at the working width
    assign e_w     = exponent_reg[WORD_BITS-1:0];
    assign m_w     = modulus_reg[WORD_BITS-1:0];
    assign m_small = (m_w < WORD_BITS'(2));

    // shared multiplier-reducer
    mexp_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .m     (m_w),
        .res   (mm_res),
        .stat  (mm_stat)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mm_start       = 1'b0;
        mm_a           = sq_reg;
        mm_b           = sq_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    sq_next    = s_axis_tdata[WORD_BITS-1:0];
                    idx_next   = '0;
                    acc_next   = m_small ? '0 : WORD_BITS'(1);
                    state_next = m_small ? S_DONE : S_RED_GO;
                end
            end
            S_RED_GO:
            begin
                // bring base below the modulus: base * 1 mod m
                mm_start   = 1'b1;
                mm_a       = sq_reg;
                mm_b       = WORD_BITS'(1);
                state_next = S_RED;
            end
            S_RED:
            begin
                if (mm_stat.done)
                begin
                    sq_next    = mm_res;
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                mm_start = 1'b1;
                if (e_w[idx_reg])
                begin
                    mm_a       = acc_reg;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                if (mm_stat.done)
                begin
                    acc_next   = mm_res;
                    state_next = S_SQR_GO;
                end
            end
            S_SQR_GO:
            begin
                mm_start   = 1'b1;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                if (mm_stat.done)
                begin
                    sq_next = mm_res;
                    if (idx_reg == IDX_W'(WORD_BITS - 1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_BIT;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mexp_pkg::DATA_W'(acc_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working values and output data
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> !mm_stat.busy)
        else $error("multiplier started while busy");

    a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (mm_stat.done && !m_small) |-> (mm_res < m_w))
        else $error("product not reduced below modulus");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIT) |-> (acc_reg < m_w) && (sq_reg < m_w))
        else $error("running values not below modulus");

    a_wait_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RED) || (state_reg == S_MUL) || (state_reg == S_SQR))
            |-> (mm_stat.busy || mm_stat.done))
        else $error("waiting on an idle multiplier");

endmodule
